// File: src/uer_pkg.sv
// Shared types and constants for the two-sensor ultrasonic ranging controller.
// Used by uer_core, ultrasonic_echo_ranger and uer_checker; depends on nothing.
package uer_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int DIST_WIDTH  = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    // distance = count * 343 / 125, tracked as quotient and remainder per tick
    localparam int SOUND_NUM   = 343;
    localparam int SOUND_DEN   = 125;
    localparam int STEP_QUO    = SOUND_NUM / SOUND_DEN;
    localparam int STEP_REM    = SOUND_NUM % SOUND_DEN;
    localparam int REM_WIDTH   = $clog2(SOUND_DEN);

    localparam logic [7:0]            RST_TRIGGER_TICKS = 8'd1;
    localparam logic [CFG_WIDTH-1:0]  RST_WAIT_LIMIT    = 16'd6250;
    localparam logic [CFG_WIDTH-1:0]  RST_ECHO_CAP      = 16'd1500;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx REG_TRIGGER_TICKS = 2'd0;
    localparam t_cfg_idx REG_WAIT_LIMIT    = 2'd1;
    localparam t_cfg_idx REG_ECHO_CAP      = 2'd2;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [CMP_WIDTH-1:0]   t_cmp;
    typedef logic [DIST_WIDTH-1:0]  t_dist;
    typedef logic [REM_WIDTH-1:0]   t_rem;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_ECHO = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0]           trigger_ticks;
        logic [CFG_WIDTH-1:0] wait_limit;
        logic [CFG_WIDTH-1:0] echo_cap;
    } t_cfg;

    typedef struct packed {
        logic command;
        logic front_sensor;
        logic echo_front;
        logic echo_back;
    } t_item;

    typedef struct packed {
        logic  trig_front;
        logic  trig_back;
        logic  busy_res;
        logic  done_res;
        t_dist distance_mm;
        logic  no_echo;
    } t_result;

endpackage

// File: src/ultrasonic_echo_ranger.sv
// Top level of the two-sensor ultrasonic ranging controller: ports, configuration
// registers, input and result registers. Uses uer_pkg and uer_core.
//
// Each input item is a timer tick (command 0) or a start (command 1) and gives exactly
// one result: the trigger levels, busy, a done pulse, the last distance in mm and the
// no-echo flag as they stand after that item. While the output is not stalled, the block
// takes one item per clock cycle. An item passes the input register, which loads at the
// transfer edge, and then the result register, which loads together with the sequencer
// state when the item advances; the sequencer update itself is combinational. Either
// side may stall at any time; a held result lets one more item into the input register,
// then the input stalls until the result transfers. Distance is kept as a running
// quotient and remainder of count*343/125, so no divider or multiplier is needed.
// Configuration writes are taken every cycle (o_cfg_ready is always high); index 3 is
// ignored.
module ultrasonic_echo_ranger (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  uer_pkg::t_cfg_idx       i_cfg_index,
    input  logic [15:0]             i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_command,
    input  logic                    i_front_sensor,
    input  logic                    i_echo_front,
    input  logic                    i_echo_back,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_trig_front,
    output logic                    o_trig_back,
    output logic                    o_busy_res,
    output logic                    o_done_res,
    output logic [15:0]             o_distance_mm,
    output logic                    o_no_echo
);
    import uer_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_res;
    t_result core_res;
    logic    advance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks <= RST_TRIGGER_TICKS;
            r_cfg.wait_limit    <= RST_WAIT_LIMIT;
            r_cfg.echo_cap      <= RST_ECHO_CAP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TRIGGER_TICKS: r_cfg.trigger_ticks <= i_cfg_data[7:0];
                REG_WAIT_LIMIT:    r_cfg.wait_limit    <= i_cfg_data;
                REG_ECHO_CAP:      r_cfg.echo_cap      <= i_cfg_data;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    // move the held item into the result register when that register frees up
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.command      <= i_command;
            r_item.front_sensor <= i_front_sensor;
            r_item.echo_front   <= i_echo_front;
            r_item.echo_back    <= i_echo_back;
        end
    end

    uer_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_trig_front  = r_res.trig_front;
    assign o_trig_back   = r_res.trig_back;
    assign o_busy_res    = r_res.busy_res;
    assign o_done_res    = r_res.done_res;
    assign o_distance_mm = r_res.distance_mm;
    assign o_no_echo     = r_res.no_echo;

endmodule

// File: src/uer_core.sv
// Measurement sequencer: phase, tick counter and running distance.
// One item is applied per i_step; o_res shows the state after that item. Uses uer_pkg.
module uer_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  uer_pkg::t_item   i_item,
    input  uer_pkg::t_cfg    i_cfg,
    output uer_pkg::t_result o_res
);
    import uer_pkg::*;

    localparam t_count COUNT_MAX = {COUNT_WIDTH{1'b1}};

    t_phase r_phase, n_phase;
    t_count r_tick, n_tick;
    logic   r_use_front, n_use_front;
    t_dist  r_last, n_last;
    t_dist  r_quo, n_quo;
    t_rem   r_rem, n_rem;

    logic        echo;
    logic        can_inc;
    t_count      tick_inc;
    logic [7:0]  rem_sum;
    logic        rem_wrap;
    t_dist       quo_inc;
    t_rem        rem_inc;
    logic        done;
    logic        miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_use_front <= 1'b0;
            r_last      <= '0;
            r_quo       <= '0;
            r_rem       <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_use_front <= n_use_front;
            r_last      <= n_last;
            r_quo       <= n_quo;
            r_rem       <= n_rem;
        end
    end

    // saturating count and the matching distance quotient/remainder one tick on
    always_comb begin
        echo     = r_use_front ? i_item.echo_front : i_item.echo_back;
        can_inc  = (r_tick != COUNT_MAX);
        tick_inc = can_inc ? r_tick + t_count'(1) : r_tick;
        rem_sum  = 8'(r_rem) + 8'(STEP_REM);
        rem_wrap = (rem_sum >= 8'(SOUND_DEN));
        if (!can_inc) begin
            quo_inc = r_quo;
            rem_inc = r_rem;
        end else if (rem_wrap) begin
            quo_inc = r_quo + t_dist'(STEP_QUO + 1);
            rem_inc = REM_WIDTH'(rem_sum - 8'(SOUND_DEN));
        end else begin
            quo_inc = r_quo + t_dist'(STEP_QUO);
            rem_inc = REM_WIDTH'(rem_sum);
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_use_front = r_use_front;
        n_last      = r_last;
        n_quo       = r_quo;
        n_rem       = r_rem;
        done        = 1'b0;
        miss        = 1'b0;
        if (i_item.command) begin
            // a start while busy is dropped
            if (r_phase == PH_IDLE) begin
                n_phase     = PH_TRIG;
                n_tick      = '0;
                n_use_front = i_item.front_sensor;
            end
        end else begin
            case (r_phase)
                PH_TRIG: begin
                    n_tick = tick_inc;
                    if (t_cmp'(tick_inc) >= t_cmp'(i_cfg.trigger_ticks)) begin
                        n_phase = PH_WAIT;
                        n_tick  = '0;
                    end
                end
                PH_WAIT: begin
                    if (echo) begin
                        n_phase = PH_ECHO;
                        n_tick  = '0;
                        n_quo   = '0;
                        n_rem   = '0;
                    end else begin
                        n_tick = tick_inc;
                        if (t_cmp'(tick_inc) >= t_cmp'(i_cfg.wait_limit)) begin
                            n_phase = PH_IDLE;
                            n_tick  = '0;
                            n_last  = '0;
                            done    = 1'b1;
                            miss    = 1'b1;
                        end
                    end
                end
                PH_ECHO: begin
                    if (echo) begin
                        n_tick = tick_inc;
                        n_quo  = quo_inc;
                        n_rem  = rem_inc;
                        if (t_cmp'(tick_inc) >= t_cmp'(i_cfg.echo_cap)) begin
                            n_phase = PH_IDLE;
                            n_tick  = '0;
                            n_last  = quo_inc;
                            done    = 1'b1;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                        n_tick  = '0;
                        n_last  = r_quo;
                        done    = 1'b1;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_comb begin
        o_res.trig_front  = (n_phase == PH_TRIG) && n_use_front;
        o_res.trig_back   = (n_phase == PH_TRIG) && !n_use_front;
        o_res.busy_res    = (n_phase != PH_IDLE);
        o_res.done_res    = done;
        o_res.distance_mm = n_last;
        o_res.no_echo     = miss;
    end

endmodule

// File: src/uer_checker.sv
// Port-level checks for ultrasonic_echo_ranger, bound to the top level below.
// Imports uer_pkg.
module uer_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_trig_front,
    input logic              o_trig_back,
    input logic              o_busy_res,
    input logic              o_done_res,
    input logic [15:0]       o_distance_mm,
    input logic              o_no_echo
);
    import uer_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_miss_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_echo |-> o_done_res && (o_distance_mm == '0))
        else $error("no-echo result without done or with nonzero distance");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("measurement finished but still busy");

    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_trig_front || o_trig_back) |-> o_busy_res
            && !(o_trig_front && o_trig_back))
        else $error("trigger level inconsistent with busy state");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_trig_front  (o_trig_front),
    .o_trig_back   (o_trig_back),
    .o_busy_res    (o_busy_res),
    .o_done_res    (o_done_res),
    .o_distance_mm (o_distance_mm),
    .o_no_echo     (o_no_echo)
);
